>>> rtl/core/mcs_pkg.sv
// Package for the coil server: request/response structs, sequencer states,
// status and exception codes, coil store geometry. No dependencies.
`default_nettype none

package mcs_pkg;

    // Coil store geometry; rows of eight coils in one RAM word
    localparam int NUM_COILS   = 256;
    localparam int ROW_W       = 8;
    localparam int NUM_ROWS    = (NUM_COILS + ROW_W - 1) / ROW_W;
    localparam int ROW_AW      = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int COIL_CNT_W  = $clog2(NUM_COILS + 1);
    localparam int MAX_RESULTS = 32;

    // Width of the shared add/subtract unit (17-bit operands, carry out on top)
    localparam int ALU_W = 17;

    // Function code flag on exception, byte mask constants
    localparam logic [7:0] FN_EXC_FLAG = 8'h80;
    localparam logic [7:0] BIT0        = 8'h01;
    localparam logic [7:0] ALL_ONES    = 8'hff;

    // Fixed response lengths
    localparam logic [5:0] LEN_BASE  = 6'd9;
    localparam logic [5:0] LEN_WRITE = 6'd12;

    typedef enum logic {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_READ_DATA = 2'd0,
        ST_WRITE_ACK = 2'd1,
        ST_EXCEPTION = 2'd2
    } t_status;

    localparam logic [1:0] EXC_NONE            = 2'd0;
    localparam logic [1:0] EXC_ILLEGAL_ADDRESS = 2'd2;

    typedef struct packed {
        logic        command;
        logic [7:0]  function_code;
        logic [15:0] start_address;
        logic [15:0] coil_quantity;
        logic        write_value;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] response_function;
        logic [5:0] byte_count;
        logic [7:0] data_byte;
        logic [1:0] exception_code;
        logic [5:0] response_length;
        logic       last;
    } t_resp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUB,
        S_WLIM,
        S_WRD,
        S_WMOD,
        S_WACK,
        S_RSUM,
        S_RLIM,
        S_RCNT,
        S_RZERO,
        S_RPRIME,
        S_RFETCH,
        S_RBYTE,
        S_EXC
    } t_state;

endpackage

`default_nettype wire

>>> rtl/core/mcs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No package dependencies.
`default_nettype none

module mcs_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 32
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [DATA_W-1:0]                          i_wdata,
    input  wire logic                                       i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [DATA_W-1:0]                          o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/modbus_coil_server_top.sv
// Coil server top level: sequencer, shared add/subtract unit, output register.
// Depends on mcs_pkg and mcs_ram.
//
// Usage:
//   Request channel i_req_valid / o_req_ready carries one t_req. Read requests
//   return one response per packed data byte (lowest coil in bit 0, last one
//   flagged); writes, empty reads and out-of-range requests return a single response.
//   Response channel o_resp_valid / i_resp_ready carries one t_resp from an
//   output register, so the sequencer keeps working while a response waits.
//   i_cfg_we / i_cfg_wdata load the address offset; write it only while idle.
// Timing:
//   One request at a time; o_req_ready is high only when the sequencer idles.
//   A write runs the offset subtract, range check, row read and row write
//   before its acknowledge. A read runs range checks and RAM priming, then
//   one byte per cycle while the output register is free, paced by the single
//   shared adder used for every check and the one RAM read port. An exception
//   follows the failing check, an empty read the byte count. The next request
//   can be taken in the cycle after the last response of a request is loaded.
// Reset (synchronous, active low) clears the offset, the output valid flag and
//   all row valid bits, so the store reads as all zero right away; no clearing
//   pass. A stalled receiver holds the response register and the sequencer
//   waits with it, nothing is dropped.
`default_nettype none

module modbus_coil_server_top (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    output logic               o_req_ready,
    input  wire mcs_pkg::t_req i_req,
    output logic               o_resp_valid,
    input  wire logic          i_resp_ready,
    output mcs_pkg::t_resp     o_resp,
    input  wire logic          i_cfg_we,
    input  wire logic [15:0]   i_cfg_wdata
);

    // State and request registers
    mcs_pkg::t_state                      r_state, n_state;
    mcs_pkg::t_req                        r_req, n_req;
    logic [15:0]                          r_offset;
    logic [15:0]                          r_idx, n_idx;
    logic [mcs_pkg::ALU_W-1:0]            r_sum, n_sum;
    logic [5:0]                           r_nbytes, n_nbytes;
    logic [5:0]                           r_len, n_len;
    logic [mcs_pkg::COIL_CNT_W-1:0]       r_left, n_left;
    logic [mcs_pkg::ROW_AW-1:0]           r_row, n_row;
    logic [mcs_pkg::ROW_W-1:0]            r_lo, n_lo;
    logic [mcs_pkg::NUM_ROWS-1:0]         r_row_vld;
    logic                                 r_rd_vld;
    mcs_pkg::t_resp                       r_out, n_out;
    logic                                 r_out_valid, n_out_valid;

    // Shared adder
    logic [mcs_pkg::ALU_W-1:0]            alu_a, alu_b;
    logic                                 alu_cin;
    logic [mcs_pkg::ALU_W:0]              alu_sum;
    logic                                 alu_carry;

    // RAM port signals
    logic                                 ram_we, ram_re;
    logic [mcs_pkg::ROW_AW-1:0]           ram_waddr, ram_raddr;
    logic [mcs_pkg::ROW_W-1:0]            ram_wdata, ram_rdata;
    logic [mcs_pkg::ROW_W-1:0]            row_eff;

    // Helpers
    logic                                 req_fire;
    logic                                 out_free;
    logic [mcs_pkg::ROW_AW-1:0]           idx_row;
    logic [mcs_pkg::ROW_AW-1:0]           row_next;
    logic [13:0]                          nb_full;
    logic [2*mcs_pkg::ROW_W-1:0]          pair_shift;
    logic [7:0]                           byte_mask;
    logic [7:0]                           byte_mask_fix;
    logic [7:0]                           wr_row;
    logic                                 is_last;

    assign req_fire = i_req_valid && o_req_ready;
    assign out_free = !r_out_valid || i_resp_ready;
    assign idx_row  = mcs_pkg::ROW_AW'(r_idx >> 3);
    assign row_next = (r_row == mcs_pkg::ROW_AW'(mcs_pkg::NUM_ROWS - 1)) ?
                      r_row : r_row + mcs_pkg::ROW_AW'(1);
    assign row_eff  = r_rd_vld ? ram_rdata : '0;

    assign alu_sum   = {1'b0, alu_a} + {1'b0, alu_b} + {{mcs_pkg::ALU_W{1'b0}}, alu_cin};
    assign alu_carry = alu_sum[mcs_pkg::ALU_W];
    assign nb_full   = alu_sum[16:3];

    // Byte assembly across two rows, masked past the requested quantity
    assign pair_shift = {row_eff, r_lo} >> r_idx[2:0];
    assign is_last    = (r_left <= mcs_pkg::COIL_CNT_W'(8));
    assign byte_mask  = is_last ? ((mcs_pkg::BIT0 << r_left[2:0]) - mcs_pkg::BIT0)
                                : mcs_pkg::ALL_ONES;
    always_comb begin
        byte_mask_fix = byte_mask;
        if (r_left == mcs_pkg::COIL_CNT_W'(8)) begin
            byte_mask_fix = mcs_pkg::ALL_ONES;
        end
    end

    // Single-coil read-modify-write of one row
    assign wr_row = (row_eff & ~(mcs_pkg::BIT0 << r_idx[2:0])) |
                    (8'(r_req.write_value) << r_idx[2:0]);

    // Coil store, eight coils per row
    mcs_ram #(
        .DATA_W (mcs_pkg::ROW_W),
        .DEPTH  (mcs_pkg::NUM_ROWS)
    ) u_coil_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Offset register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (i_cfg_we) begin
            r_offset <= i_cfg_wdata;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mcs_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_row_vld   <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (ram_we) begin
                r_row_vld[ram_waddr] <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_idx    <= n_idx;
        r_sum    <= n_sum;
        r_nbytes <= n_nbytes;
        r_len    <= n_len;
        r_left   <= n_left;
        r_row    <= n_row;
        r_lo     <= n_lo;
        r_out    <= n_out;
        if (ram_re) begin
            r_rd_vld <= r_row_vld[ram_raddr];
        end
    end

    // Sequencer: next state, shared adder operands, RAM control, response load
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_idx       = r_idx;
        n_sum       = r_sum;
        n_nbytes    = r_nbytes;
        n_len       = r_len;
        n_left      = r_left;
        n_row       = r_row;
        n_lo        = r_lo;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_resp_ready;
        alu_a       = '0;
        alu_b       = '0;
        alu_cin     = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = idx_row;
        ram_wdata   = wr_row;
        ram_re      = 1'b0;
        ram_raddr   = r_row;
        o_req_ready = (r_state == mcs_pkg::S_IDLE);

        case (r_state)
            mcs_pkg::S_IDLE: begin
                if (req_fire) begin
                    n_req   = i_req;
                    n_state = mcs_pkg::S_SUB;
                end
            end
            // index = start - offset, borrow means below offset
            mcs_pkg::S_SUB: begin
                alu_a   = {1'b0, r_req.start_address};
                alu_b   = ~{1'b0, r_offset};
                alu_cin = 1'b1;
                n_idx   = alu_sum[15:0];
                if (!alu_carry) begin
                    n_state = mcs_pkg::S_EXC;
                end else if (r_req.command == mcs_pkg::CMD_WRITE) begin
                    n_state = mcs_pkg::S_WLIM;
                end else begin
                    n_state = mcs_pkg::S_RSUM;
                end
            end
            // write: index < NUM_COILS
            mcs_pkg::S_WLIM: begin
                alu_a   = {1'b0, r_idx};
                alu_b   = ~mcs_pkg::ALU_W'(mcs_pkg::NUM_COILS);
                alu_cin = 1'b1;
                n_state = alu_carry ? mcs_pkg::S_EXC : mcs_pkg::S_WRD;
            end
            mcs_pkg::S_WRD: begin
                ram_re    = 1'b1;
                ram_raddr = idx_row;
                n_state   = mcs_pkg::S_WMOD;
            end
            mcs_pkg::S_WMOD: begin
                ram_we  = 1'b1;
                n_state = mcs_pkg::S_WACK;
            end
            mcs_pkg::S_WACK: begin
                if (out_free) begin
                    n_out.status            = mcs_pkg::ST_WRITE_ACK;
                    n_out.response_function = r_req.function_code;
                    n_out.byte_count        = '0;
                    n_out.data_byte         = '0;
                    n_out.exception_code    = mcs_pkg::EXC_NONE;
                    n_out.response_length   = mcs_pkg::LEN_WRITE;
                    n_out.last              = 1'b1;
                    n_out_valid             = 1'b1;
                    n_state                 = mcs_pkg::S_IDLE;
                end
            end
            // read: index + quantity
            mcs_pkg::S_RSUM: begin
                alu_a   = {1'b0, r_idx};
                alu_b   = {1'b0, r_req.coil_quantity};
                n_sum   = alu_sum[mcs_pkg::ALU_W-1:0];
                n_state = mcs_pkg::S_RLIM;
            end
            // read: index + quantity <= NUM_COILS
            mcs_pkg::S_RLIM: begin
                alu_a   = r_sum;
                alu_b   = ~mcs_pkg::ALU_W'(mcs_pkg::NUM_COILS + 1);
                alu_cin = 1'b1;
                n_state = alu_carry ? mcs_pkg::S_EXC : mcs_pkg::S_RCNT;
            end
            // byte count = (quantity + 7) / 8
            mcs_pkg::S_RCNT: begin
                alu_a    = {1'b0, r_req.coil_quantity};
                alu_b    = mcs_pkg::ALU_W'(7);
                n_nbytes = nb_full[5:0];
                n_len    = mcs_pkg::LEN_BASE + nb_full[5:0];
                n_left   = mcs_pkg::COIL_CNT_W'(r_req.coil_quantity);
                n_row    = idx_row;
                if (nb_full > 14'(mcs_pkg::MAX_RESULTS)) begin
                    n_state = mcs_pkg::S_EXC;
                end else if (nb_full == '0) begin
                    n_state = mcs_pkg::S_RZERO;
                end else begin
                    n_state = mcs_pkg::S_RPRIME;
                end
            end
            mcs_pkg::S_RZERO: begin
                if (out_free) begin
                    n_out.status            = mcs_pkg::ST_READ_DATA;
                    n_out.response_function = r_req.function_code;
                    n_out.byte_count        = '0;
                    n_out.data_byte         = '0;
                    n_out.exception_code    = mcs_pkg::EXC_NONE;
                    n_out.response_length   = mcs_pkg::LEN_BASE;
                    n_out.last              = 1'b1;
                    n_out_valid             = 1'b1;
                    n_state                 = mcs_pkg::S_IDLE;
                end
            end
            // first row read
            mcs_pkg::S_RPRIME: begin
                ram_re  = 1'b1;
                n_row   = row_next;
                n_state = mcs_pkg::S_RFETCH;
            end
            // second row read, first row lands
            mcs_pkg::S_RFETCH: begin
                ram_re  = 1'b1;
                n_lo    = row_eff;
                n_row   = row_next;
                n_state = mcs_pkg::S_RBYTE;
            end
            // one byte per cycle while the output register drains
            mcs_pkg::S_RBYTE: begin
                alu_a   = mcs_pkg::ALU_W'(r_left);
                alu_b   = ~mcs_pkg::ALU_W'(8);
                alu_cin = 1'b1;
                if (out_free) begin
                    n_out.status            = mcs_pkg::ST_READ_DATA;
                    n_out.response_function = r_req.function_code;
                    n_out.byte_count        = r_nbytes;
                    n_out.data_byte         = pair_shift[7:0] & byte_mask_fix;
                    n_out.exception_code    = mcs_pkg::EXC_NONE;
                    n_out.response_length   = r_len;
                    n_out.last              = is_last;
                    n_out_valid             = 1'b1;
                    if (is_last) begin
                        n_state = mcs_pkg::S_IDLE;
                    end else begin
                        n_left = alu_sum[mcs_pkg::COIL_CNT_W-1:0];
                        n_lo   = row_eff;
                        ram_re = 1'b1;
                        n_row  = row_next;
                    end
                end
            end
            mcs_pkg::S_EXC: begin
                if (out_free) begin
                    n_out.status            = mcs_pkg::ST_EXCEPTION;
                    n_out.response_function = r_req.function_code | mcs_pkg::FN_EXC_FLAG;
                    n_out.byte_count        = '0;
                    n_out.data_byte         = '0;
                    n_out.exception_code    = mcs_pkg::EXC_ILLEGAL_ADDRESS;
                    n_out.response_length   = mcs_pkg::LEN_BASE;
                    n_out.last              = 1'b1;
                    n_out_valid             = 1'b1;
                    n_state                 = mcs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mcs_pkg::S_IDLE;
            end
        endcase
    end

    assign o_resp_valid = r_out_valid;
    assign o_resp       = r_out;

    // Accepting a request always takes the sequencer out of idle
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_fire |=> !o_req_ready)
        else $error("ready stayed high after a request was taken");

    // Exceptions carry the flagged function code and the address exception
    a_exc_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_resp_valid && o_resp.status == mcs_pkg::ST_EXCEPTION) |->
        (o_resp.response_function[7] &&
         o_resp.exception_code == mcs_pkg::EXC_ILLEGAL_ADDRESS))
        else $error("exception response fields inconsistent");

    // Read responses: length tracks byte count
    a_read_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_resp_valid && o_resp.status == mcs_pkg::ST_READ_DATA) |->
        (o_resp.response_length == mcs_pkg::LEN_BASE + o_resp.byte_count))
        else $error("read response length mismatch");

    // The byte loop never runs with no coils left
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mcs_pkg::S_RBYTE) |-> (r_left != '0))
        else $error("byte loop entered with zero coils left");

endmodule

`default_nettype wire

>>> tb/tb_modbus_coil_server_top.sv
// Testbench for modbus_coil_server_top: a directed table, then random coil
// reads and writes under several offsets and handshake mixes, checked against
// an in-bench coil store model. Depends on mcs_pkg and the coil server RTL.
`timescale 1ns / 100ps

module tb_modbus_coil_server_top;

    localparam int          HALF_PERIOD  = 2;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          RAND_PER_PH  = 99;
    localparam int          COIL_AW      = $clog2(mcs_pkg::NUM_COILS);
    localparam logic [7:0]  FC_READ_COILS = 8'h01;
    localparam logic [7:0]  FC_WRITE_COIL = 8'h05;

    // One row of the directed table: an offset write or a request
    typedef struct packed {
        logic           is_cfg;
        logic [15:0]    cfg_val;
        mcs_pkg::t_req  req;
        logic           typed;
        mcs_pkg::t_resp want;
    } t_row;

    logic           i_clk        = 1'b0;
    logic           i_rst_n      = 1'b0;
    logic           i_req_valid  = 1'b0;
    logic           o_req_ready;
    mcs_pkg::t_req  i_req        = '0;
    logic           o_resp_valid;
    logic           i_resp_ready = 1'b0;
    mcs_pkg::t_resp o_resp;
    logic           i_cfg_we     = 1'b0;
    logic [15:0]    i_cfg_wdata  = '0;

    // Coil store model and its offset
    logic [mcs_pkg::NUM_COILS-1:0] coil_img = '0;
    logic [15:0]                   model_offset = '0;

    mcs_pkg::t_resp due_resp[$];
    mcs_pkg::t_resp calc_q[$];
    t_row           dir_rows[$];

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    int err_count   = 0;
    int n_req       = 0;
    int n_data      = 0;
    int n_ack       = 0;
    int n_exc       = 0;
    int n_zero_read = 0;

    modbus_coil_server_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .o_req_ready  (o_req_ready),
        .i_req        (i_req),
        .o_resp_valid (o_resp_valid),
        .i_resp_ready (i_resp_ready),
        .o_resp       (o_resp),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Hard stop in case the block hangs
    initial begin
        #10_000_000;
        $display("tb_modbus_coil_server_top: done, errors");
        $finish;
    end

    function automatic mcs_pkg::t_resp mk_resp(input logic [1:0] status,
                                               input logic [7:0] fn,
                                               input logic [5:0] bcount,
                                               input logic [7:0] dbyte,
                                               input logic [1:0] exc,
                                               input logic [5:0] len,
                                               input logic last);
        mcs_pkg::t_resp e;
        e.status            = status;
        e.response_function = fn;
        e.byte_count        = bcount;
        e.data_byte         = dbyte;
        e.exception_code    = exc;
        e.response_length   = len;
        e.last              = last;
        return e;
    endfunction

    function automatic mcs_pkg::t_resp exc_resp(input logic [7:0] fn);
        return mk_resp(mcs_pkg::ST_EXCEPTION, fn | mcs_pkg::FN_EXC_FLAG, '0, '0,
                       mcs_pkg::EXC_ILLEGAL_ADDRESS, mcs_pkg::LEN_BASE, 1'b1);
    endfunction

    function automatic mcs_pkg::t_req mk_req(input logic cmd, input logic [7:0] fn,
                                             input logic [15:0] start,
                                             input logic [15:0] qty,
                                             input logic val);
        mcs_pkg::t_req r;
        r.command       = cmd;
        r.function_code = fn;
        r.start_address = start;
        r.coil_quantity = qty;
        r.write_value   = val;
        return r;
    endfunction

    // Responses one request causes; updates the coil store model on writes
    function automatic void predict_coils(input mcs_pkg::t_req r);
        int         idx;
        int         qty;
        int         nbytes;
        int         n;
        logic [7:0] dbyte;
        calc_q.delete();
        if (r.start_address < model_offset) begin
            calc_q.push_back(exc_resp(r.function_code));
            return;
        end
        idx = int'(r.start_address) - int'(model_offset);
        if (r.command == mcs_pkg::CMD_WRITE) begin
            if (idx >= mcs_pkg::NUM_COILS) begin
                calc_q.push_back(exc_resp(r.function_code));
                return;
            end
            coil_img[COIL_AW'(idx)] = r.write_value;
            calc_q.push_back(mk_resp(mcs_pkg::ST_WRITE_ACK, r.function_code, '0, '0,
                                     mcs_pkg::EXC_NONE, mcs_pkg::LEN_WRITE, 1'b1));
            return;
        end
        qty    = int'(r.coil_quantity);
        nbytes = (qty + 7) / 8;
        if (idx + qty > mcs_pkg::NUM_COILS || nbytes > mcs_pkg::MAX_RESULTS) begin
            calc_q.push_back(exc_resp(r.function_code));
            return;
        end
        if (nbytes == 0) begin
            calc_q.push_back(mk_resp(mcs_pkg::ST_READ_DATA, r.function_code, '0, '0,
                                     mcs_pkg::EXC_NONE, mcs_pkg::LEN_BASE, 1'b1));
            return;
        end
        // Pack coils LSB first; bits past the quantity stay zero
        for (int k = 0; k < nbytes; k++) begin
            dbyte = '0;
            for (int b = 0; b < 8; b++) begin
                n = k * 8 + b;
                if (n < qty && coil_img[COIL_AW'(idx + n)])
                    dbyte[b] = 1'b1;
            end
            calc_q.push_back(mk_resp(mcs_pkg::ST_READ_DATA, r.function_code, 6'(nbytes),
                                     dbyte, mcs_pkg::EXC_NONE,
                                     mcs_pkg::LEN_BASE + 6'(nbytes), k == nbytes - 1));
        end
    endfunction

    // Random request: mostly addresses that land in the store, some noise
    function automatic mcs_pkg::t_req gen_request();
        mcs_pkg::t_req r;
        int            kind;
        int            idx;
        int            qty;
        r.command       = 1'($urandom_range(0, 1));
        r.function_code = 8'($urandom_range(0, 255));
        r.start_address = 16'($urandom_range(0, 65535));
        r.coil_quantity = 16'($urandom_range(0, 65535));
        r.write_value   = 1'($urandom_range(0, 1));
        kind = $urandom_range(0, 99);
        if (kind < 80) begin
            if ($urandom_range(0, 99) < 70)
                r.function_code = (r.command == mcs_pkg::CMD_WRITE) ? FC_WRITE_COIL
                                                                    : FC_READ_COILS;
            idx = (kind < 4) ? mcs_pkg::NUM_COILS
                             : int'($urandom_range(0, mcs_pkg::NUM_COILS - 1));
            r.start_address = model_offset + 16'(idx);
            if (kind < 55)
                qty = $urandom_range(0, 40);
            else if (kind < 65)
                qty = mcs_pkg::NUM_COILS - idx;
            else if (kind < 70)
                qty = mcs_pkg::NUM_COILS - idx + 1;
            else
                qty = $urandom_range(0, mcs_pkg::NUM_COILS - idx);
            r.coil_quantity = 16'(qty);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Offer one request, starting and ending at a falling edge
    task automatic send_req(input mcs_pkg::t_req r, input logic typed,
                            input mcs_pkg::t_resp want);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_req_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        do @(posedge i_clk); while (!o_req_ready);
        n_req++;
        predict_coils(r);
        if (typed)
            due_resp.push_back(want);
        else
            foreach (calc_q[i]) due_resp.push_back(calc_q[i]);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every response is back and the block idles
    task automatic wait_idle();
        i_req_valid <= 1'b0;
        do @(posedge i_clk); while (due_resp.size() != 0 || !o_req_ready);
        @(negedge i_clk);
    endtask

    task automatic write_offset(input logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        model_offset = val;
    endtask

    task automatic add_req(input mcs_pkg::t_req r, input logic typed,
                           input mcs_pkg::t_resp want);
        t_row row;
        row = '0;
        row.req   = r;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    task automatic add_cfg(input logic [15:0] val);
        t_row row;
        row = '0;
        row.is_cfg  = 1'b1;
        row.cfg_val = val;
        dir_rows.push_back(row);
    endtask

    // Receiver: random stalls, plus a long hold-off when the main flow asks
    always @(negedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_resp_ready <= 1'b0;
        end else begin
            i_resp_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Response checker
    always @(posedge i_clk) begin
        mcs_pkg::t_resp want;
        if (i_rst_n && o_resp_valid && i_resp_ready) begin
            if (due_resp.size() == 0) begin
                report_mismatch("response with nothing due", 32'(o_resp), 32'h0);
            end else begin
                want = due_resp.pop_front();
                check_field("status", 32'(o_resp.status), 32'(want.status));
                check_field("response_function", 32'(o_resp.response_function),
                            32'(want.response_function));
                check_field("byte_count", 32'(o_resp.byte_count), 32'(want.byte_count));
                check_field("data_byte", 32'(o_resp.data_byte), 32'(want.data_byte));
                check_field("exception_code", 32'(o_resp.exception_code),
                            32'(want.exception_code));
                check_field("response_length", 32'(o_resp.response_length),
                            32'(want.response_length));
                check_field("last", 32'(o_resp.last), 32'(want.last));
            end
            case (o_resp.status)
                mcs_pkg::ST_READ_DATA: begin
                    if (o_resp.byte_count == 0)
                        n_zero_read++;
                    else
                        n_data++;
                end
                mcs_pkg::ST_WRITE_ACK: n_ack++;
                default:               n_exc++;
            endcase
        end
    end

    // Main flow
    initial begin
        mcs_pkg::t_resp none;
        mcs_pkg::t_resp exc85;
        mcs_pkg::t_resp ack85;
        logic [15:0]    ph_offset [4];
        int             ph_tx [4];
        int             ph_rx [4];
        none  = '0;
        exc85 = exc_resp(FC_WRITE_COIL);
        ack85 = mk_resp(mcs_pkg::ST_WRITE_ACK, FC_WRITE_COIL, '0, '0, mcs_pkg::EXC_NONE,
                        mcs_pkg::LEN_WRITE, 1'b1);

        // Directed table, offset zero after reset
        add_req(mk_req(mcs_pkg::CMD_READ, FC_READ_COILS, 16'd0, 16'd8, 1'b0), 1'b1,
                mk_resp(mcs_pkg::ST_READ_DATA, FC_READ_COILS, 6'd1, 8'h00,
                        mcs_pkg::EXC_NONE, 6'd10, 1'b1));
        add_req(mk_req(mcs_pkg::CMD_READ, FC_READ_COILS, 16'd0, 16'd0, 1'b0), 1'b1,
                mk_resp(mcs_pkg::ST_READ_DATA, FC_READ_COILS, 6'd0, 8'h00,
                        mcs_pkg::EXC_NONE, mcs_pkg::LEN_BASE, 1'b1));
        add_req(mk_req(mcs_pkg::CMD_WRITE, FC_WRITE_COIL, 16'd0, 16'hffff, 1'b1), 1'b1,
                ack85);
        add_req(mk_req(mcs_pkg::CMD_WRITE, FC_WRITE_COIL, 16'd255, 16'd0, 1'b1), 1'b1,
                ack85);
        add_req(mk_req(mcs_pkg::CMD_WRITE, FC_WRITE_COIL, 16'd256, 16'd0, 1'b1), 1'b1,
                exc85);
        // Bit 7 already set stays set on the exception
        add_req(mk_req(mcs_pkg::CMD_WRITE, 8'hff, 16'hffff, 16'hffff, 1'b0), 1'b1,
                exc_resp(8'hff));
        add_req(mk_req(mcs_pkg::CMD_WRITE, FC_WRITE_COIL, 16'd9, 16'd0, 1'b1), 1'b0,
                none);
        add_req(mk_req(mcs_pkg::CMD_READ, FC_READ_COILS, 16'd0, 16'd256, 1'b0), 1'b0,
                none);
        add_req(mk_req(mcs_pkg::CMD_READ, FC_READ_COILS, 16'd1, 16'd256, 1'b0), 1'b1,
                exc_resp(FC_READ_COILS));
        // Oversized read: more bytes than the block returns
        add_req(mk_req(mcs_pkg::CMD_READ, FC_READ_COILS, 16'd0, 16'd257, 1'b0), 1'b1,
                exc_resp(FC_READ_COILS));
        add_req(mk_req(mcs_pkg::CMD_READ, FC_READ_COILS, 16'd0, 16'hffff, 1'b0), 1'b1,
                exc_resp(FC_READ_COILS));
        add_req(mk_req(mcs_pkg::CMD_READ, 8'h00, 16'hffff, 16'd1, 1'b0), 1'b1,
                exc_resp(8'h00));
        // Partial last byte: bits past the quantity read as zero
        add_req(mk_req(mcs_pkg::CMD_READ, FC_READ_COILS, 16'd250, 16'd6, 1'b0), 1'b0,
                none);
        add_req(mk_req(mcs_pkg::CMD_READ, FC_READ_COILS, 16'd0, 16'd10, 1'b0), 1'b0,
                none);
        // Largest offset: only address ffff maps into the store
        add_cfg(16'hffff);
        add_req(mk_req(mcs_pkg::CMD_READ, FC_READ_COILS, 16'hfffe, 16'd1, 1'b0), 1'b1,
                exc_resp(FC_READ_COILS));
        add_req(mk_req(mcs_pkg::CMD_WRITE, FC_WRITE_COIL, 16'hffff, 16'd0, 1'b0), 1'b1,
                ack85);
        add_req(mk_req(mcs_pkg::CMD_READ, FC_READ_COILS, 16'hffff, 16'd1, 1'b0), 1'b0,
                none);
        add_cfg(16'd100);
        add_req(mk_req(mcs_pkg::CMD_WRITE, FC_WRITE_COIL, 16'd99, 16'd0, 1'b1), 1'b1,
                exc85);
        add_req(mk_req(mcs_pkg::CMD_WRITE, FC_WRITE_COIL, 16'd355, 16'd0, 1'b1), 1'b1,
                ack85);
        add_req(mk_req(mcs_pkg::CMD_WRITE, FC_WRITE_COIL, 16'd356, 16'd0, 1'b1), 1'b1,
                exc85);
        add_req(mk_req(mcs_pkg::CMD_READ, FC_READ_COILS, 16'd100, 16'd256, 1'b0), 1'b0,
                none);
        add_req(mk_req(mcs_pkg::CMD_READ, 8'h81, 16'd101, 16'd255, 1'b0), 1'b0, none);
        // Zero quantity at the very end of the store is still in range
        add_req(mk_req(mcs_pkg::CMD_READ, FC_READ_COILS, 16'd356, 16'd0, 1'b0), 1'b1,
                mk_resp(mcs_pkg::ST_READ_DATA, FC_READ_COILS, 6'd0, 8'h00,
                        mcs_pkg::EXC_NONE, mcs_pkg::LEN_BASE, 1'b1));

        // Reset
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                wait_idle();
                write_offset(dir_rows[i].cfg_val);
            end else begin
                send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        // Random phases: offset and handshake mix per phase
        ph_offset[0] = 16'h0000;
        ph_offset[1] = 16'($urandom_range(1, 16'hfe00));
        ph_offset[2] = 16'hff00;
        ph_offset[3] = 16'($urandom_range(1, 16'hfe00));
        ph_tx[0] = 0;  ph_rx[0] = 0;
        ph_tx[1] = 64; ph_rx[1] = 0;
        ph_tx[2] = 0;  ph_rx[2] = 64;
        ph_tx[3] = 13; ph_rx[3] = 13;
        for (int p = 0; p < 4; p++) begin
            wait_idle();
            write_offset(ph_offset[p]);
            tx_idle_pct  = ph_tx[p];
            rx_stall_pct = ph_rx[p];
            // Long receiver hold-off while requests keep coming
            if (p == 0)
                hold_requests++;
            for (int i = 0; i < RAND_PER_PH; i++)
                send_req(gen_request(), 1'b0, none);
        end

        wait_idle();
        rx_stall_pct = 0;
        repeat (20) @(posedge i_clk);

        $display("%0d requests: %0d read bytes, %0d empty reads, %0d write acks, %0d exceptions",
                 n_req, n_data, n_zero_read, n_ack, n_exc);
        $display("offsets 0, ffff, ff00 and random; idle, sender-gap, receiver-stall and mixed");
        if (err_count == 0)
            $display("tb_modbus_coil_server_top: done, clean");
        else
            $display("tb_modbus_coil_server_top: done, errors");
        $finish;
    end

endmodule

>>> modbus_coil_server_top.f
rtl/core/mcs_pkg.sv
rtl/core/mcs_ram.sv
rtl/core/modbus_coil_server_top.sv
tb/tb_modbus_coil_server_top.sv
